### hw/rtl/cfsg_pkg.sv
// ----------------------------------------------------------------------------
// cfsg_pkg: shared types and constants for the command frame safety gate
// Word formats, configuration indexes, counter sizing and queue sizing.
// ----------------------------------------------------------------------------
package cfsg_pkg;

  // Width of the elapsed millisecond counter (range 10 to 32).
  localparam int CounterWidth = 16;
  // Compare width that holds both the counter and the 16-bit timeout.
  localparam int CmpWidth     = (CounterWidth > 16) ? CounterWidth : 16;

  localparam logic [15:0] SyncWordReset  = 16'hABCD;
  localparam logic [15:0] TimeoutReset   = 16'd500;

  // Depth of the result queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic {
    CfgSyncWord = 1'b0,
    CfgTimeout  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CmdRxByte = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  typedef enum logic {
    KindStop = 1'b0,
    KindHeld = 1'b1
  } frame_kind_e;

  // Byte positions within a frame, counted from the first start byte.
  localparam logic [2:0] PosSteerLo = 3'd2;
  localparam logic [2:0] PosSteerHi = 3'd3;
  localparam logic [2:0] PosSpeedLo = 3'd4;
  localparam logic [2:0] PosSpeedHi = 3'd5;
  localparam logic [2:0] PosCheckLo = 3'd6;
  localparam logic [2:0] PosCheckHi = 3'd7;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       button_level;
  } in_word_t;

  typedef struct packed {
    logic               frame_kind;
    logic        [15:0] start_field;
    logic signed [15:0] steer_value;
    logic signed [15:0] speed_value;
    logic        [15:0] check_value;
  } out_word_t;

endpackage

### hw/rtl/cfsg_front.sv
// ----------------------------------------------------------------------------
// cfsg_front: frame parser and safety decision
// Hunts for the sync word, assembles and checks frames, counts milliseconds
// and decides per word whether a stop frame or the held frame goes out.
// ----------------------------------------------------------------------------
module cfsg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfsg_pkg::in_word_t in_word_i,
  input  logic               q_ready_i,
  output logic               push_valid_o,
  output cfsg_pkg::out_word_t push_word_o
);
  import cfsg_pkg::*;

  logic [15:0] sync_word_q, timeout_q;
  logic [15:0] sync_shift_q, sync_shift_d;
  logic        receiving_q, receiving_d;
  logic [2:0]  byte_idx_q, byte_idx_d;
  logic [15:0] steer_q, steer_d, speed_q, speed_d;
  logic [7:0]  check_lo_q, check_lo_d;
  logic [15:0] held_start_q, held_start_d, held_steer_q, held_steer_d;
  logic [15:0] held_speed_q, held_speed_d, held_check_q, held_check_d;
  logic        pending_q, pending_d;
  logic [CounterWidth-1:0] elapsed_q, elapsed_d;

  logic        accept;
  logic        stop;
  logic        emit_held;
  logic [15:0] shift_nx;
  logic [15:0] check_full;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SyncWordReset;
      timeout_q   <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSyncWord: sync_word_q <= cfg_data_i;
        CfgTimeout:  timeout_q   <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    sync_shift_d = sync_shift_q;
    receiving_d  = receiving_q;
    byte_idx_d   = byte_idx_q;
    steer_d      = steer_q;
    speed_d      = speed_q;
    check_lo_d   = check_lo_q;
    held_start_d = held_start_q;
    held_steer_d = held_steer_q;
    held_speed_d = held_speed_q;
    held_check_d = held_check_q;
    pending_d    = pending_q;
    elapsed_d    = elapsed_q;
    shift_nx     = {in_word_i.rx_byte, sync_shift_q[15:8]};
    check_full   = {in_word_i.rx_byte, check_lo_q};
    stop         = 1'b0;
    emit_held    = 1'b0;

    if (accept) begin
      if (cmd_e'(in_word_i.command) == CmdTick) begin
        if (!(&elapsed_q)) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end else if (!receiving_q) begin
        sync_shift_d = shift_nx;
        if (shift_nx == sync_word_q) begin
          receiving_d = 1'b1;
          byte_idx_d  = PosSteerLo;
        end
      end else begin
        byte_idx_d = byte_idx_q + 1'b1;
        unique case (byte_idx_q)
          PosSteerLo: steer_d[7:0]  = in_word_i.rx_byte;
          PosSteerHi: steer_d[15:8] = in_word_i.rx_byte;
          PosSpeedLo: speed_d[7:0]  = in_word_i.rx_byte;
          PosSpeedHi: speed_d[15:8] = in_word_i.rx_byte;
          PosCheckLo: check_lo_d    = in_word_i.rx_byte;
          PosCheckHi: begin
            // Last byte: check the XOR sum, then go back to hunting.
            if ((sync_shift_q ^ steer_q ^ speed_q) == check_full) begin
              held_start_d = sync_shift_q;
              held_steer_d = steer_q;
              held_speed_d = speed_q;
              held_check_d = check_full;
              elapsed_d    = '0;
            end
            sync_shift_d = '0;
            receiving_d  = 1'b0;
            byte_idx_d   = '0;
            pending_d    = 1'b1;
          end
          default: ;
        endcase
      end

      stop = !in_word_i.button_level ||
             (CmpWidth'(elapsed_d) > CmpWidth'(timeout_q));
      if (!stop && pending_d) begin
        emit_held = 1'b1;
        pending_d = 1'b0;
      end
    end
  end

  assign push_valid_o = stop | emit_held;

  always_comb begin
    if (stop) begin
      push_word_o.frame_kind  = KindStop;
      push_word_o.start_field = sync_word_q;
      push_word_o.steer_value = '0;
      push_word_o.speed_value = '0;
      push_word_o.check_value = sync_word_q;
    end else begin
      push_word_o.frame_kind  = KindHeld;
      push_word_o.start_field = held_start_d;
      push_word_o.steer_value = held_steer_d;
      push_word_o.speed_value = held_speed_d;
      push_word_o.check_value = held_check_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_shift_q <= '0;
      receiving_q  <= 1'b0;
      byte_idx_q   <= '0;
      held_start_q <= '0;
      held_steer_q <= '0;
      held_speed_q <= '0;
      held_check_q <= '0;
      pending_q    <= 1'b0;
      elapsed_q    <= '0;
    end else begin
      sync_shift_q <= sync_shift_d;
      receiving_q  <= receiving_d;
      byte_idx_q   <= byte_idx_d;
      held_start_q <= held_start_d;
      held_steer_q <= held_steer_d;
      held_speed_q <= held_speed_d;
      held_check_q <= held_check_d;
      pending_q    <= pending_d;
      elapsed_q    <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steer_q    <= steer_d;
    speed_q    <= speed_d;
    check_lo_q <= check_lo_d;
  end

endmodule

### hw/rtl/cfsg_queue.sv
// ----------------------------------------------------------------------------
// cfsg_queue: result queue and output stage
// Small FIFO of result words that decouples the parser from the consumer.
// ----------------------------------------------------------------------------
module cfsg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  cfsg_pkg::out_word_t push_word_i,
  output logic                q_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfsg_pkg::out_word_t out_word_o
);
  import cfsg_pkg::*;

  out_word_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_push, do_pop;

  assign q_ready_o   = (count_q != (QueuePtrW+1)'(QueueDepth));
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign do_push     = push_valid_i & q_ready_o;
  assign do_pop      = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/command_frame_safety_gate.sv
// ----------------------------------------------------------------------------
// command_frame_safety_gate: serial command frame parser with safety gate
// Parses sync-framed steer/speed commands and forces a stop frame on a low
// button level or a command timeout.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Word
//  in        input      in_valid_i/in_ready_o   in_word_i  (byte or ms tick)
//  out       output     out_valid_o/out_ready_i out_word_o (frame to send)
//  cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// The block takes one input word per cycle; input ready drops only when the
// four-entry queue is full. The parser state is updated in the cycle of
// acceptance, so the next word can follow immediately. A result is queued
// at the edge that accepts its word. Reset restores sync word 0xABCD and
// timeout 500 ms and clears all parser state but the steer, speed and check
// assembly bytes; no clearing pass is needed, so words are taken right after
// reset. Configuration writes take effect at the edge where cfg_we_i is high.
//
module command_frame_safety_gate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfsg_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfsg_pkg::out_word_t out_word_o
);
  import cfsg_pkg::*;

  logic      q_ready;
  logic      push_valid;
  out_word_t push_word;

  // Front: frame hunting, assembly, checksum, timeout and output decision.
  cfsg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .q_ready_i    (q_ready),
    .push_valid_o (push_valid),
    .push_word_o  (push_word)
  );

  // Back: queue of finished frames, drained by the consumer at its own pace.
  cfsg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .q_ready_o    (q_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

### tb/tb_command_frame_safety_gate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_safety_gate: self-checking bench for the frame safety gate
// Directed tests for reset values, stop frames, relaying, checksums and
// timeouts, then random traffic checked against a predictor.
// ----------------------------------------------------------------------------
module tb_command_frame_safety_gate;
  import cfsg_pkg::*;

  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 9;
  // Idle margin covering the result queue and words that produce no frame at all.
  localparam int SettleCycles = 8;
  // A stall of this many cycles with no handshake on either side is a hang.
  localparam int QuietLimit   = 4000;
  localparam int ReportMax    = 10;
  localparam int PhaseWords   = 275;

  // Every input is known from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = CfgSyncWord;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;

  // Traffic shaping, set by the test tasks and read by the drivers.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Predictor copy of the configuration and of the gate state.
  logic [15:0]             sync_cfg    = SyncWordReset;
  logic [15:0]             timeout_cfg = TimeoutReset;
  logic [15:0]             sync_win    = '0;
  logic                    in_frame    = 1'b0;
  logic [3:0]              byte_pos    = '0;
  logic [15:0]             asm_word [3];
  logic [15:0]             hold_start  = '0;
  logic [15:0]             hold_steer  = '0;
  logic [15:0]             hold_speed  = '0;
  logic [15:0]             hold_check  = '0;
  logic                    relay_due   = 1'b0;
  logic [CounterWidth-1:0] elapsed_q   = '0;

  // Frames that the gate owes us, oldest first.
  out_word_t frames_due [$];
  out_word_t want_frame;

  int words_sent  = 0;
  int ticks_sent  = 0;
  int stop_seen   = 0;
  int relay_seen  = 0;
  int fault_cnt   = 0;
  int quiet_count = 0;

  command_frame_safety_gate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Works out what one accepted word does to the gate and queues the frame it
  // sends, if any. Bytes hunt for the sync word, low byte first; once it is
  // seen, the next six bytes fill steer, speed and check in that order.
  function void step_gate_model(in_word_t w);
    logic [2:0]  pos;
    int          slot;
    logic [15:0] sum;
    out_word_t   r;
    if (w.command == CmdTick) begin
      if (elapsed_q != {CounterWidth{1'b1}}) begin
        elapsed_q = elapsed_q + 1'b1;
      end
    end else if (!in_frame) begin
      sync_win = {w.rx_byte, sync_win[15:8]};
      if (sync_win == sync_cfg) begin
        in_frame = 1'b1;
        byte_pos = 4'd2;
      end
    end else begin
      pos  = 3'(byte_pos - 4'd2);
      slot = (pos >> 1) % 3;
      if (!pos[0]) begin
        asm_word[slot][7:0] = w.rx_byte;
      end else begin
        asm_word[slot][15:8] = w.rx_byte;
      end
      byte_pos = byte_pos + 4'd1;
      if (byte_pos >= 4'd8) begin
        // The start kept in the window is the one that matched, even if the
        // sync word was rewritten since.
        sum = sync_win ^ asm_word[0] ^ asm_word[1];
        if (sum == asm_word[2]) begin
          hold_start = sync_win;
          hold_steer = asm_word[0];
          hold_speed = asm_word[1];
          hold_check = asm_word[2];
          elapsed_q  = '0;
        end
        // A bad checksum still marks a frame as due, so the old one goes again.
        sync_win  = '0;
        in_frame  = 1'b0;
        byte_pos  = '0;
        relay_due = 1'b1;
      end
    end

    if (!w.button_level || 32'(elapsed_q) > 32'(timeout_cfg)) begin
      // The stop frame leaves a due relay in place for later.
      r.frame_kind  = KindStop;
      r.start_field = sync_cfg;
      r.steer_value = '0;
      r.speed_value = '0;
      r.check_value = sync_cfg;
      frames_due.push_back(r);
    end else if (relay_due) begin
      relay_due     = 1'b0;
      r.frame_kind  = KindHeld;
      r.start_field = hold_start;
      r.steer_value = hold_steer;
      r.speed_value = hold_speed;
      r.check_value = hold_check;
      frames_due.push_back(r);
    end
  endfunction

  // Everything is sampled at the rising edge, before any of that edge's
  // updates land, so the bench sees exactly what the gate saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= ReportMax) begin
            $display("Unexpected frame at %0t: kind %0d start %h steer %h speed %h check %h",
                     $time, out_word_o.frame_kind, out_word_o.start_field,
                     out_word_o.steer_value, out_word_o.speed_value, out_word_o.check_value);
          end
        end else begin
          want_frame = frames_due.pop_front();
          if (out_word_o.frame_kind  !== want_frame.frame_kind  ||
              out_word_o.start_field !== want_frame.start_field ||
              out_word_o.steer_value !== want_frame.steer_value ||
              out_word_o.speed_value !== want_frame.speed_value ||
              out_word_o.check_value !== want_frame.check_value) begin
            fault_cnt++;
            if (fault_cnt <= ReportMax) begin
              $display("Frame mismatch at %0t: expected kind %0d start %h steer %h speed %h check %h",
                       $time, want_frame.frame_kind, want_frame.start_field,
                       want_frame.steer_value, want_frame.speed_value,
                       want_frame.check_value);
              $display("  got kind %0d start %h steer %h speed %h check %h",
                       out_word_o.frame_kind, out_word_o.start_field,
                       out_word_o.steer_value, out_word_o.speed_value,
                       out_word_o.check_value);
            end
          end else if (out_word_o.frame_kind == KindStop) begin
            stop_seen++;
          end else begin
            relay_seen++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSyncWord: sync_cfg    = cfg_data_i;
          CfgTimeout:  timeout_cfg = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_o) begin
        words_sent++;
        if (in_word_i.command == CmdTick) begin
          ticks_sent++;
        end
        step_gate_model(in_word_i);
      end
    end
  end

  // The receiver drops ready at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a long stretch with no word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QuietLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d frames outstanding",
               QuietLimit, frames_due.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays high
  // on return so a following word can go out back to back.
  task automatic send_word(input cmd_e cmd, input logic [7:0] b, input logic btn);
    in_word_t w;
    w.command      = cmd;
    w.rx_byte      = b;
    w.button_level = btn;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_tick(input logic btn);
    send_word(CmdTick, 8'($urandom), btn);
  endtask

  // Sends the first n_bytes bytes of a frame, little endian. A set bit in
  // tick_mask puts a tick ahead of that byte; btn_mask gives each byte's button.
  task automatic send_frame(input logic [15:0] start, input logic [15:0] steer,
                            input logic [15:0] speed, input logic [15:0] chk,
                            input logic [7:0] tick_mask, input logic [7:0] btn_mask,
                            input int n_bytes);
    logic [63:0] flat;
    flat = {chk, speed, steer, start};
    for (int i = 0; i < n_bytes; i++) begin
      if (tick_mask[i]) begin
        send_tick(1'b1);
      end
      send_word(CmdRxByte, flat[8*i +: 8], btn_mask[i]);
    end
  endtask

  // Drops valid, waits for every owed frame and then lets the pipeline go
  // quiet, so a register write cannot race a word in flight.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A low button on the very first word gives a stop frame built from the
  // reset sync word.
  task automatic test_stop_after_reset();
    send_word(CmdRxByte, 8'h00, 1'b0);
  endtask

  // A frame with a bad checksum before any good one relays the all-zero frame.
  task automatic test_relay_before_valid();
    send_frame(sync_cfg, 16'h1111, 16'h2222, ~(sync_cfg ^ 16'h1111 ^ 16'h2222),
               8'h00, 8'hFF, 8);
  endtask

  // Good frames carrying the most negative, most positive and all-ones values.
  task automatic test_valid_frame_extremes();
    send_frame(sync_cfg, 16'h8000, 16'h7FFF, sync_cfg ^ 16'h8000 ^ 16'h7FFF,
               8'h00, 8'hFF, 8);
    send_frame(sync_cfg, 16'hFFFF, 16'h0000, sync_cfg ^ 16'hFFFF,
               8'h00, 8'hFF, 8);
  endtask

  // The last byte comes with the button low, so a stop frame goes out first;
  // the relay is still due and leaves on the next word with the button high.
  task automatic test_stop_keeps_relay();
    send_frame(sync_cfg, 16'h0001, 16'hFFFF, sync_cfg ^ 16'h0001 ^ 16'hFFFF,
               8'h00, 8'h7F, 8);
    send_tick(1'b1);
  endtask

  // A bad checksum keeps the held frame, which is sent again.
  task automatic test_bad_check_resends();
    send_frame(sync_cfg, 16'h1234, 16'h5678, sync_cfg ^ 16'h1234,
               8'h00, 8'hFF, 8);
  endtask

  // Ticks between the bytes must not upset frame assembly.
  task automatic test_ticks_mid_frame();
    send_frame(sync_cfg, 16'hC3A5, 16'h0F81, sync_cfg ^ 16'hC3A5 ^ 16'h0F81,
               8'b1010_0110, 8'hFF, 8);
  endtask

  // The sync word changes after the start is matched; the frame keeps the old
  // start. A frame with the new sync word follows.
  task automatic test_sync_change_mid_frame();
    logic [15:0] old_sync;
    logic [63:0] flat;
    old_sync = sync_cfg;
    flat = {old_sync ^ 16'h0102 ^ 16'h0304, 16'h0304, 16'h0102, old_sync};
    send_frame(old_sync, 16'h0102, 16'h0304, flat[63:48], 8'h00, 8'hFF, 3);
    settle_idle();
    write_reg(CfgSyncWord, 16'h5AA5);
    for (int i = 3; i < 8; i++) begin
      send_word(CmdRxByte, flat[8*i +: 8], 1'b1);
    end
    send_frame(sync_cfg, 16'h7E7E, 16'h8181, sync_cfg ^ 16'h7E7E ^ 16'h8181,
               8'h00, 8'hFF, 8);
  endtask

  // With a zero timeout one tick forces a stop and a good frame lifts it.
  // With a timeout of three, the fourth tick is the first to force a stop.
  task automatic test_timeout_limits();
    settle_idle();
    write_reg(CfgTimeout, 16'd0);
    send_tick(1'b1);
    send_frame(sync_cfg, 16'h0400, 16'hFC00, sync_cfg ^ 16'h0400 ^ 16'hFC00,
               8'h00, 8'hFF, 8);
    settle_idle();
    write_reg(CfgTimeout, 16'd3);
    repeat (4) send_tick(1'b1);
  endtask

  // A frame with random content, mostly with a good checksum, sometimes with
  // ticks inside, a low button, or cut short so the next frame is swallowed.
  task automatic send_random_frame();
    logic [15:0] steer;
    logic [15:0] speed;
    logic [15:0] chk;
    logic [7:0]  tick_mask;
    logic [7:0]  btn_mask;
    int          n_bytes;
    steer = 16'($urandom);
    speed = 16'($urandom);
    chk   = ($urandom_range(99) < 80) ? (sync_cfg ^ steer ^ speed) : 16'($urandom);
    for (int i = 0; i < 8; i++) begin
      tick_mask[i] = ($urandom_range(99) < 12);
      btn_mask[i]  = ($urandom_range(99) >= 4);
    end
    n_bytes = ($urandom_range(99) < 8) ? $urandom_range(1, 7) : 8;
    send_frame(sync_cfg, steer, speed, chk, tick_mask, btn_mask, n_bytes);
  endtask

  // Runs of ticks long enough to reach small timeouts, or a few stray bytes.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 24);
    if ($urandom_range(1) == 0) begin
      repeat (n) send_word(CmdTick, 8'($urandom), $urandom_range(99) >= 6);
    end else begin
      repeat ((n + 5) / 6) send_word(CmdRxByte, 8'($urandom), $urandom_range(99) >= 6);
    end
  endtask

  task automatic run_traffic_phase(input int idle_pct, input int stall_v,
                                   input logic [15:0] sync_v, input logic [15:0] tmo_v);
    int base;
    settle_idle();
    write_reg(CfgSyncWord, sync_v);
    write_reg(CfgTimeout, tmo_v);
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    base          = words_sent;
    while (words_sent - base < PhaseWords) begin
      if ($urandom_range(99) < 75) begin
        send_random_frame();
      end else begin
        send_noise();
      end
    end
  endtask

  // Four mixes of idling and stalls, each with its own sync word and timeout,
  // among them sync words 0x0000 and 0xFFFF and timeouts 0 and 65534.
  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 16'($urandom), 16'($urandom_range(4, 30)));
    run_traffic_phase(68, 0, 16'h0000, 16'd0);
    run_traffic_phase(0, 68, 16'hFFFF, 16'($urandom_range(5, 40)));
    run_traffic_phase(25, 25, 16'($urandom), 16'd65534);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stop_after_reset();
    test_relay_before_valid();
    test_valid_frame_extremes();
    test_stop_keeps_relay();
    test_bad_check_resends();
    test_ticks_mid_frame();
    test_sync_change_mid_frame();
    test_timeout_limits();
    test_random_traffic();

    settle_idle();
    if (frames_due.size() != 0) begin
      $display("%0d expected frames never arrived", frames_due.size());
    end
    $display("Sent %0d words including %0d ms ticks; checked %0d stop and %0d relayed frames.",
             words_sent, ticks_sent, stop_seen, relay_seen);
    $display("Sync words 0x0000 and 0xFFFF, timeouts 0 to 65534; %0d faults.",
             fault_cnt);
    if (fault_cnt == 0 && frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cfsg_pkg.sv
hw/rtl/cfsg_front.sv
hw/rtl/cfsg_queue.sv
hw/rtl/command_frame_safety_gate.sv
tb/tb_command_frame_safety_gate.sv
